// ===== rtl/sbtd_pkg.sv =====
// Shared constants, control word types and microprogram for the single-bin tone detector.
`default_nettype none

package sbtd_pkg;

  localparam int SAMPLE_W         = 8;
  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int COEFF_FRAC_BITS  = 30;
  localparam int DATA_W           = 32;
  localparam int BLEN_W           = 12;
  localparam int MAG_W            = 63;
  localparam int CFG_IDX_W        = 1;

  localparam int OPND_W    = DATA_W + 1;
  localparam int MUL_W     = 2 * OPND_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 97;
  localparam int MAG_SHIFT = SAMPLE_FRAC_BITS + COEFF_FRAC_BITS;

  localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(205);

  localparam logic [CFG_IDX_W-1:0] REG_COEF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEN = 1'b1;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_FETCH   = 4'd0;
  localparam logic [PC_W-1:0] STEP_UPDATE  = 4'd1;
  localparam logic [PC_W-1:0] STEP_SQ1     = 4'd2;
  localparam logic [PC_W-1:0] STEP_SQ2     = 4'd3;
  localparam logic [PC_W-1:0] STEP_CROSS   = 4'd4;
  localparam logic [PC_W-1:0] STEP_TLOAD   = 4'd5;
  localparam logic [PC_W-1:0] STEP_CLO     = 4'd6;
  localparam logic [PC_W-1:0] STEP_CHI     = 4'd7;
  localparam logic [PC_W-1:0] STEP_FINISH  = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT    = 4'd9;

  typedef enum logic [1:0] {A_Q1, A_Q2, A_TLO, A_THI} mul_a_e;
  typedef enum logic [1:0] {B_COEF, B_Q1, B_Q2} mul_b_e;
  typedef enum logic [2:0] {ACC_HOLD, ACC_SET_SQ, ACC_ADD_SQ, ACC_SUB_LO, ACC_SUB_HI} acc_op_e;
  typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_e;
  typedef enum logic [1:0] {BR_SEQ, BR_JUMP, BR_JUMP_UNLESS_END} br_e;

  typedef struct packed {
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    acc_op_e acc_op;
    logic    take;
    logic    t_load;
    logic    upd;
    logic    emit;
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    wait_e           wait_on;
    br_e             br;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic   fire;
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic block_end;
    logic out_free;
  } dp_status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w.op.mul_a  = A_Q1;
    w.op.mul_b  = B_COEF;
    w.op.acc_op = ACC_HOLD;
    w.op.take   = 1'b0;
    w.op.t_load = 1'b0;
    w.op.upd    = 1'b0;
    w.op.emit   = 1'b0;
    w.wait_on   = WAIT_NONE;
    w.br        = BR_SEQ;
    w.target    = STEP_FETCH;
    case (pc)
      STEP_FETCH: begin
        w.op.take = 1'b1;
        w.wait_on = WAIT_IN;
      end
      STEP_UPDATE: begin
        w.op.upd = 1'b1;
        w.br     = BR_JUMP_UNLESS_END;
      end
      STEP_SQ1: begin
        w.op.mul_b = B_Q1;
      end
      STEP_SQ2: begin
        w.op.acc_op = ACC_SET_SQ;
        w.op.mul_a  = A_Q2;
        w.op.mul_b  = B_Q2;
      end
      STEP_CROSS: begin
        w.op.acc_op = ACC_ADD_SQ;
        w.op.mul_b  = B_Q2;
      end
      STEP_TLOAD: begin
        w.op.t_load = 1'b1;
      end
      STEP_CLO: begin
        w.op.mul_a = A_TLO;
      end
      STEP_CHI: begin
        w.op.acc_op = ACC_SUB_LO;
        w.op.mul_a  = A_THI;
      end
      STEP_FINISH: begin
        w.op.acc_op = ACC_SUB_HI;
      end
      STEP_EMIT: begin
        w.op.emit = 1'b1;
        w.wait_on = WAIT_OUT;
        w.br      = BR_JUMP;
      end
      default: begin
        w.br = BR_JUMP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbtd_sequencer.sv =====
// Microprogram sequencer: step counter, control ROM, wait and branch logic.
`default_nettype none

module sbtd_sequencer (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  sbtd_pkg::dp_status_t   status_i,
  output sbtd_pkg::dp_ctrl_t     ctrl_o,
  output logic                   idle_o
);
  import sbtd_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            fire;

  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.wait_on)
      WAIT_NONE: fire = 1'b1;
      WAIT_IN:   fire = in_valid_i;
      WAIT_OUT:  fire = status_i.out_free;
      default:   fire = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      case (uw.br)
        BR_SEQ:             pc_d = pc_q + 1'b1;
        BR_JUMP:            pc_d = uw.target;
        BR_JUMP_UNLESS_END: pc_d = status_i.block_end ? pc_q + 1'b1 : uw.target;
        default:            pc_d = STEP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.fire = fire;
  assign ctrl_o.op   = uw.op;
  assign idle_o      = (uw.wait_on == WAIT_IN);

endmodule

`default_nettype wire

// ===== rtl/sbtd_datapath.sv =====
// Datapath: shared multiplier, Goertzel state, magnitude accumulator and output register.
`default_nettype none

module sbtd_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  sbtd_pkg::dp_ctrl_t                ctrl_i,
  input  wire  [sbtd_pkg::SAMPLE_W-1:0]     sample_value_i,
  input  wire  [sbtd_pkg::DATA_W-1:0]       coef_i,
  input  wire  [sbtd_pkg::BLEN_W-1:0]       blen_i,
  output sbtd_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [sbtd_pkg::MAG_W-1:0]        magnitude_squared_o,
  output logic                              saturated_o
);
  import sbtd_pkg::*;

  logic        [DATA_W-1:0]   q1_q, q1_d, q2_q, q2_d;
  logic        [BLEN_W-1:0]   cnt_q, cnt_d, cnt_inc;
  logic        [SAMPLE_W-1:0] sample_q;
  logic signed [MUL_W-1:0]    p_q, p_d;
  logic        [PROD_W-1:0]   t_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d, acc_p, acc_sq, acc_hi;
  logic signed [OPND_W-1:0]   opa, opb;
  logic        [DATA_W-1:0]   next_val;
  logic                       out_valid_q, out_valid_d;
  logic        [MAG_W-1:0]    mag_q, mag_d;
  logic                       sat_q;
  logic                       out_free;

  always_comb begin
    case (ctrl_i.op.mul_a)
      A_Q1:    opa = {q1_q[DATA_W-1], q1_q};
      A_Q2:    opa = {q2_q[DATA_W-1], q2_q};
      A_TLO:   opa = {1'b0, t_q[DATA_W-1:0]};
      A_THI:   opa = {t_q[PROD_W-1], t_q[PROD_W-1:DATA_W]};
      default: opa = '0;
    endcase
    case (ctrl_i.op.mul_b)
      B_COEF:  opb = {coef_i[DATA_W-1], coef_i};
      B_Q1:    opb = {q1_q[DATA_W-1], q1_q};
      B_Q2:    opb = {q2_q[DATA_W-1], q2_q};
      default: opb = '0;
    endcase
    p_d = opa * opb;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  // floor(c*Q1 / 2^30) wraps to 32 bits, then the recursion
  assign next_val = p_q[COEFF_FRAC_BITS +: DATA_W] - q2_q
                  + (DATA_W'(sample_q) << SAMPLE_FRAC_BITS);
  assign cnt_inc  = cnt_q + 1'b1;

  assign status_o.block_end = (cnt_inc == '0) || (cnt_inc >= blen_i);
  assign out_free           = !out_valid_q || !out_stall_i;
  assign status_o.out_free  = out_free;

  always_comb begin
    q1_d  = q1_q;
    q2_d  = q2_q;
    cnt_d = cnt_q;
    if (ctrl_i.fire && ctrl_i.op.upd) begin
      q1_d  = next_val;
      q2_d  = q1_q;
      cnt_d = cnt_inc;
    end
    if (ctrl_i.fire && ctrl_i.op.emit) begin
      q1_d  = '0;
      q2_d  = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q  <= '0;
      q2_q  <= '0;
      cnt_q <= '0;
    end else begin
      q1_q  <= q1_d;
      q2_q  <= q2_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && ctrl_i.op.take) begin
      sample_q <= sample_value_i;
    end
    if (ctrl_i.fire && ctrl_i.op.t_load) begin
      t_q <= p_q[PROD_W-1:0];
    end
  end

  // N = (Q1^2 + Q2^2) * 2^30 - Q1*Q2*c, built from 33x33 partial products
  assign acc_p  = ACC_W'(p_q);
  assign acc_sq = acc_p <<< COEFF_FRAC_BITS;
  assign acc_hi = acc_p <<< DATA_W;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.op.acc_op)
        ACC_HOLD:   acc_d = acc_q;
        ACC_SET_SQ: acc_d = acc_sq;
        ACC_ADD_SQ: acc_d = acc_q + acc_sq;
        ACC_SUB_LO: acc_d = acc_q - acc_p;
        ACC_SUB_HI: acc_d = acc_q - acc_hi;
        default:    acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // |N| < 2^95, so N >> 46 always fits below 2^63: no clamp at the top
  assign mag_d = acc_q[ACC_W-1] ? '0 : MAG_W'(acc_q[ACC_W-2:MAG_SHIFT]);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.fire && ctrl_i.op.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && ctrl_i.op.emit) begin
      mag_q <= mag_d;
      sat_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign magnitude_squared_o = mag_q;
  assign saturated_o         = sat_q;

endmodule

`default_nettype wire

// ===== rtl/single_bin_tone_detector_top.sv =====
// Top level of the single-bin tone detector: configuration registers, sequencer and datapath.
`default_nettype none

// Goertzel single-bin detector. Each accepted 8-bit sample passes the fetch step,
// which forms the coefficient product on the shared 33x33 multiplier, and the
// update step, which applies the recursion. After the last sample of a block the
// squared magnitude is built from five more products on the same multiplier,
// with any wait for the output register to drain. The result is the squared
// magnitude scaled by 2^16; the accumulators clear after each block. Write the
// coefficient (index 0, signed Q2.30) and block length (index 1) while idle.

module single_bin_tone_detector_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [sbtd_pkg::SAMPLE_W-1:0]       sample_value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [sbtd_pkg::MAG_W-1:0]          magnitude_squared_o,
  output logic                                saturated_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [sbtd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [sbtd_pkg::DATA_W-1:0]         cfg_data_i
);
  import sbtd_pkg::*;

  logic [DATA_W-1:0] coef_q;
  logic [BLEN_W-1:0] blen_q;
  dp_ctrl_t          ctrl;
  dp_status_t        status;
  logic              idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      blen_q <= BLEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COEF: coef_q <= cfg_data_i;
        REG_BLEN: blen_q <= cfg_data_i[BLEN_W-1:0];
        default:  ;
      endcase
    end
  end

  sbtd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  sbtd_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .sample_value_i      (sample_value_i),
    .coef_i              (coef_q),
    .blen_i              (blen_q),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .magnitude_squared_o (magnitude_squared_o),
    .saturated_o         (saturated_o)
  );

  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

endmodule

`default_nettype wire
